[rtl/bba_pkg.sv]
// Shared types and constants of the bitmap block allocator.
`default_nettype none

package bba_pkg;

  // Field widths of the item ports and the register port.
  localparam int BLK_W  = 16;
  localparam int CNT_W  = 17;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Action codes of an input item.
  localparam logic [ACT_W-1:0] ACT_FORMAT  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd4;

  // Status codes of a result item.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

  // Register index, taken from address bit 2.
  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  localparam logic [CNT_W-1:0] TOTAL_RESET = 17'h10000;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 17'h1FFFF;

  // Datapath operations issued by the controller.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL        = 4'd2;
  localparam logic [OP_W-1:0] OP_SPLIT      = 4'd3;
  localparam logic [OP_W-1:0] OP_SWEEP_INIT = 4'd4;
  localparam logic [OP_W-1:0] OP_SWEEP      = 4'd5;
  localparam logic [OP_W-1:0] OP_FMT_DONE   = 4'd6;
  localparam logic [OP_W-1:0] OP_SCAN_START = 4'd7;
  localparam logic [OP_W-1:0] OP_SCAN_READ  = 4'd8;
  localparam logic [OP_W-1:0] OP_SCAN_NEXT  = 4'd9;
  localparam logic [OP_W-1:0] OP_ALLOC_HIT  = 4'd10;
  localparam logic [OP_W-1:0] OP_ALLOC_MISS = 4'd11;
  localparam logic [OP_W-1:0] OP_BIT_READ   = 4'd12;
  localparam logic [OP_W-1:0] OP_BIT_DONE   = 4'd13;
  localparam logic [OP_W-1:0] OP_PASS       = 4'd14;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            use_res;
  } bba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             in_range;
    logic             free_zero;
    logic             sweep_last;
    logic             past_total;
    logic             word_free;
    logic             next_past;
  } bba_stat_t;

  // Configuration register contents.
  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] reserved;
  } bba_cfg_t;

endpackage

`default_nettype wire

[rtl/bba_cfg.sv]
// Configuration registers of the bitmap block allocator behind an APB-style port.
`default_nettype none

module bba_cfg
  import bba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output bba_cfg_t               cfg
);

  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] reserved_r;
  logic             wr_en;
  logic             reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= TOTAL_RESET;
      reserved_r <= '0;
    end else if (wr_en) begin
      if (reg_sel == REG_TOTAL) begin
        total_r <= pwdata[CNT_W-1:0];
      end else begin
        reserved_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  // Read data mux.
  assign prdata = (reg_sel == REG_TOTAL) ? APB_DW'(total_r) : APB_DW'(reserved_r);

  assign cfg.total    = total_r;
  assign cfg.reserved = reserved_r;

endmodule

`default_nettype wire

[rtl/bba_ctrl.sv]
// Controller state machine of the bitmap block allocator.
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire bba_stat_t stat,
  output bba_cmd_t       cmd
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_CLR      = 4'd1;
  localparam logic [3:0] S_IDLE     = 4'd2;
  localparam logic [3:0] S_DISP     = 4'd3;
  localparam logic [3:0] S_SPLIT    = 4'd4;
  localparam logic [3:0] S_BIT_RD   = 4'd5;
  localparam logic [3:0] S_BIT_DONE = 4'd6;
  localparam logic [3:0] S_SWEEP    = 4'd7;
  localparam logic [3:0] S_FMT_DONE = 4'd8;
  localparam logic [3:0] S_SCAN_RD  = 4'd9;
  localparam logic [3:0] S_SCAN_CHK = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_nxt   = state_r;
    cmd.op      = OP_NONE;
    cmd.use_res = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.op    = OP_SWEEP_INIT;
        state_nxt = S_CLR;
      end
      // Clearing pass after reset: every map word is written with zeros.
      S_CLR: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.action == ACT_FORMAT) begin
          cmd.op    = OP_SWEEP_INIT;
          state_nxt = S_SWEEP;
        end else if (stat.action == ACT_ALLOC) begin
          if (stat.free_zero) begin
            cmd.op    = OP_ALLOC_MISS;
            state_nxt = S_IDLE;
          end else begin
            cmd.op    = OP_SCAN_START;
            state_nxt = S_SCAN_RD;
          end
        end else if ((stat.action inside {ACT_RELEASE, ACT_READ, ACT_WRITE}) &&
                     stat.in_range) begin
          cmd.op    = OP_MUL;
          state_nxt = S_SPLIT;
        end else begin
          cmd.op    = OP_PASS;
          state_nxt = S_IDLE;
        end
      end
      S_SPLIT: begin
        cmd.op    = OP_SPLIT;
        state_nxt = S_BIT_RD;
      end
      S_BIT_RD: begin
        cmd.op    = OP_BIT_READ;
        state_nxt = S_BIT_DONE;
      end
      S_BIT_DONE: begin
        cmd.op    = OP_BIT_DONE;
        state_nxt = S_IDLE;
      end
      // Format pass: reserved bits set, all others cleared.
      S_SWEEP: begin
        cmd.op      = OP_SWEEP;
        cmd.use_res = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_FMT_DONE;
        end
      end
      S_FMT_DONE: begin
        cmd.op    = OP_FMT_DONE;
        state_nxt = S_IDLE;
      end
      S_SCAN_RD: begin
        if (stat.past_total) begin
          cmd.op    = OP_ALLOC_MISS;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_SCAN_READ;
          state_nxt = S_SCAN_CHK;
        end
      end
      // One map word is checked per cycle while the next one is read.
      S_SCAN_CHK: begin
        if (stat.word_free) begin
          cmd.op    = OP_ALLOC_HIT;
          state_nxt = S_IDLE;
        end else if (stat.next_past) begin
          cmd.op    = OP_ALLOC_MISS;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_SCAN_NEXT;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/bba_dp.sv]
// Datapath of the bitmap block allocator: usage map memory, pointers, counters and results.
`default_nettype none

module bba_dp
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS    = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bba_cmd_t          cmd,
  output bba_stat_t              stat,
  input  wire bba_cfg_t          cfg,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [BLK_W-1:0]  in_block_number,
  input  wire logic              in_bit_value,
  output logic                   out_valid,
  output logic      [STAT_W-1:0] out_status,
  output logic      [BLK_W-1:0]  out_result_block,
  output logic                   out_read_value,
  output logic      [CNT_W-1:0]  out_free_blocks
);

  localparam int W      = MAP_WORD_BITS;
  localparam int WORDS  = (NUM_BLOCKS + W - 1) / W;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OW     = $clog2(W);
  localparam int BW_RAW = $clog2(WORDS * W + W) + 1;
  localparam int BW     = (BW_RAW > CNT_W + 1) ? BW_RAW : CNT_W + 1;
  // Block number split by a reciprocal multiply, exact for all 16-bit numbers.
  localparam int DIV_S  = BLK_W + $clog2(W);
  localparam int DIV_MW = DIV_S - 1;
  localparam int PW     = BLK_W + DIV_MW;
  localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'((2 ** DIV_S) / W + 1);
  localparam int NB_W   = $clog2(NUM_BLOCKS + 1);
  localparam int CW     = (NB_W > CNT_W) ? NB_W : CNT_W;
  localparam logic [CW-1:0] NB_C      = CW'(NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [BW-1:0] W_B       = BW'(W);

  // Bits of a word whose block number base+b lies below lim.
  function automatic logic [W-1:0] low_mask(input logic [BW-1:0] lim,
                                            input logic [BW-1:0] base);
    logic [BW-1:0] d;
    logic [W-1:0]  m;
    d = (lim > base) ? (lim - base) : '0;
    for (int b = 0; b < W; b++) begin
      m[b] = (d > BW'(b));
    end
    return m;
  endfunction

  // Usage map memory, one port, registered read data.
  logic [W-1:0]  mem [WORDS];
  logic [W-1:0]  rdata_r;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [W-1:0]  mem_wdata;

  // Item registers.
  logic [ACT_W-1:0]  act_r;
  logic [BLK_W-1:0]  blk_r;
  logic              bitv_r;
  logic [PW-1:0]     prod_r;
  logic [AW-1:0]     addr_r;
  logic [BW-1:0]     wbase_r;
  logic [OW-1:0]     boff_r;

  // Sweep and scan pointer, first-fit hint and free count.
  logic [AW-1:0]     ptr_r;
  logic [BW-1:0]     base_r;
  logic [AW-1:0]     hint_w_r;
  logic [BW-1:0]     hint_b_r;
  logic [CNT_W-1:0]  free_r;

  // Result registers.
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [BLK_W-1:0]  rblock_r;
  logic              rval_r;

  // Effective total and reserved count.
  logic [CNT_W-1:0] tot;
  logic [CNT_W-1:0] res;
  logic [BW-1:0]    tot_b;
  logic [BW-1:0]    res_b;

  assign tot   = (CW'(cfg.total) > NB_C) ? CNT_W'(NB_C) : cfg.total;
  assign res   = (cfg.reserved < tot) ? cfg.reserved : tot;
  assign tot_b = BW'(tot);
  assign res_b = BW'(res);

  // Word index, word base and bit offset of the item's block.
  logic [BLK_W-1:0] quo;
  logic [BW-1:0]    qbase;
  logic [OW-1:0]    qoff;

  assign quo   = BLK_W'(prod_r >> DIV_S);
  assign qbase = BW'(quo) * W_B;
  assign qoff  = OW'(BW'(blk_r) - qbase);

  // Sweep word and scan search.
  logic [BW-1:0] next_base;
  logic [W-1:0]  sweep_word;
  logic          sweep_full;
  logic [W-1:0]  vmask;
  logic [W-1:0]  cand;
  logic [OW-1:0] idx;
  logic [BW-1:0] found_n;
  logic [W-1:0]  hit_mask;
  logic [W-1:0]  bit_mask;
  logic          cur_bit;

  assign next_base  = base_r + W_B;
  assign sweep_word = cmd.use_res ? low_mask(res_b, base_r) : '0;
  assign sweep_full = cmd.use_res && (next_base <= res_b);
  assign vmask      = low_mask(tot_b, base_r);
  assign cand       = ~rdata_r & vmask;

  // Lowest free bit of the current word.
  always_comb begin
    idx = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        idx = OW'(b);
      end
    end
  end

  assign found_n  = base_r + BW'(idx);
  assign hit_mask = W'(1) << idx;
  assign bit_mask = W'(1) << boff_r;
  assign cur_bit  = |(rdata_r & bit_mask);

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = ptr_r;
    mem_wdata = sweep_word;
    case (cmd.op)
      OP_SWEEP: begin
        mem_we = 1'b1;
      end
      OP_SCAN_READ: begin
        mem_re = 1'b1;
      end
      OP_SCAN_NEXT: begin
        mem_re   = 1'b1;
        mem_addr = ptr_r + AW'(1);
      end
      OP_ALLOC_HIT: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r | hit_mask;
      end
      OP_BIT_READ: begin
        mem_re   = 1'b1;
        mem_addr = addr_r;
      end
      OP_BIT_DONE: begin
        mem_addr = addr_r;
        if (act_r == ACT_RELEASE) begin
          mem_we    = cur_bit;
          mem_wdata = rdata_r & ~bit_mask;
        end else if (act_r == ACT_WRITE) begin
          mem_we    = 1'b1;
          mem_wdata = bitv_r ? (rdata_r | bit_mask) : (rdata_r & ~bit_mask);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Free count, first-fit hint and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= '0;
      hint_w_r    <= '0;
      hint_b_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_ALLOC_HIT) || (cmd.op == OP_ALLOC_MISS) ||
                     (cmd.op == OP_BIT_DONE) || (cmd.op == OP_PASS) ||
                     (cmd.op == OP_FMT_DONE);
      case (cmd.op)
        OP_SWEEP_INIT: begin
          hint_w_r <= '0;
          hint_b_r <= '0;
        end
        // Leading fully reserved words need not be searched.
        OP_SWEEP: begin
          if (sweep_full) begin
            hint_w_r <= ptr_r + AW'(1);
            hint_b_r <= next_base;
          end
        end
        OP_FMT_DONE: begin
          free_r <= tot - res;
        end
        OP_ALLOC_HIT: begin
          free_r   <= free_r - CNT_W'(1);
          hint_w_r <= ptr_r;
          hint_b_r <= base_r;
        end
        OP_BIT_DONE: begin
          if ((act_r == ACT_RELEASE) && cur_bit && (free_r != COUNT_MAX)) begin
            free_r <= free_r + CNT_W'(1);
          end
          // A bit that may become free pulls the hint back to its word.
          if (((act_r == ACT_RELEASE) || ((act_r == ACT_WRITE) && !bitv_r)) &&
              (wbase_r < hint_b_r)) begin
            hint_w_r <= addr_r;
            hint_b_r <= wbase_r;
          end
        end
        default: begin
          free_r <= free_r;
        end
      endcase
    end
  end

  // Item, pointer and result registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act_r  <= in_action;
        blk_r  <= in_block_number;
        bitv_r <= in_bit_value;
      end
      OP_MUL: begin
        prod_r <= PW'(blk_r) * PW'(DIV_M);
      end
      OP_SPLIT: begin
        addr_r  <= AW'(quo);
        wbase_r <= qbase;
        boff_r  <= qoff;
      end
      OP_SWEEP_INIT: begin
        ptr_r  <= '0;
        base_r <= '0;
      end
      OP_SWEEP, OP_SCAN_NEXT: begin
        ptr_r  <= ptr_r + AW'(1);
        base_r <= next_base;
      end
      OP_SCAN_START: begin
        ptr_r  <= hint_w_r;
        base_r <= hint_b_r;
      end
      OP_FMT_DONE: begin
        status_r <= ST_OK;
        rblock_r <= '0;
        rval_r   <= 1'b0;
      end
      OP_ALLOC_HIT: begin
        status_r <= ST_OK;
        rblock_r <= BLK_W'(found_n);
        rval_r   <= 1'b0;
      end
      OP_ALLOC_MISS: begin
        status_r <= ST_NO_SPACE;
        rblock_r <= '0;
        rval_r   <= 1'b0;
      end
      OP_BIT_DONE: begin
        status_r <= ST_OK;
        rblock_r <= blk_r;
        rval_r   <= (act_r == ACT_READ) && cur_bit;
      end
      OP_PASS: begin
        status_r <= (act_r inside {ACT_RELEASE, ACT_READ, ACT_WRITE}) ? ST_RANGE : ST_OK;
        rblock_r <= blk_r;
        rval_r   <= 1'b0;
      end
      default: begin
        status_r <= status_r;
      end
    endcase
  end

  // Status to the controller.
  assign stat.action     = act_r;
  assign stat.in_range   = (CNT_W'(blk_r) < tot);
  assign stat.free_zero  = (free_r == '0);
  assign stat.sweep_last = (ptr_r == LAST_WORD);
  assign stat.past_total = (base_r >= tot_b);
  assign stat.word_free  = |cand;
  assign stat.next_past  = (next_base >= tot_b);

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_result_block = rblock_r;
  assign out_read_value   = rval_r;
  assign out_free_blocks  = free_r;

endmodule

`default_nettype wire

[rtl/bitmap_block_allocator.sv]
// Top level of the bitmap block allocator: register port, controller and datapath.
//
// The block takes one item at a time: an item is taken when start is high and busy is low,
// and its result appears on the out_ ports for exactly one cycle with out_valid high; the
// receiver must take it then. An in-range release, read bit or write bit passes through the
// multiply, split, bit read and bit update states; an unused action, an out-of-range number
// and an allocate with no free count are answered from dispatch; any other allocate reads
// map words from the first-fit hint word onward until one has a free bit below the total or
// the total is passed: the map sits in a single-port memory of NUM_BLOCKS / MAP_WORD_BITS
// words, rounded up, and the search reads one word per cycle. Format writes every map word
// once. After reset a clearing pass runs with busy high; register writes are taken at any
// time but must only change while no item runs.
`default_nettype none

module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS    = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [BLK_W-1:0]  in_block_number,
  input  wire logic              in_bit_value,
  output logic                   out_valid,
  output logic      [STAT_W-1:0] out_status,
  output logic      [BLK_W-1:0]  out_result_block,
  output logic                   out_read_value,
  output logic      [CNT_W-1:0]  out_free_blocks,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  bba_cfg_t  cfg;
  bba_cmd_t  cmd;
  bba_stat_t stat;

  bba_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bba_dp #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg              (cfg),
    .in_action        (in_action),
    .in_block_number  (in_block_number),
    .in_bit_value     (in_bit_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_block (out_result_block),
    .out_read_value   (out_read_value),
    .out_free_blocks  (out_free_blocks)
  );

endmodule

`default_nettype wire

[rtl/bba_checker.sv]
// Port-level checks of the bitmap block allocator, bound to its top level.
`default_nettype none

module bba_checker
  import bba_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [BLK_W-1:0]  out_result_block,
  input wire logic [CNT_W-1:0]  out_free_blocks
);

  // Every item passes through the load in idle and the dispatch state, so strobes never come back to back.
  a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe high in two consecutive cycles");

  // A result is given as the item ends, when the block is ready again.
  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after taking an item");

  // The free count only moves together with a result.
  a_free_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> $stable(out_free_blocks))
    else $error("free count changed without a result");

  // A failed allocation reports block zero and a known status.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_OK) || (out_status == ST_RANGE) ||
                   ((out_status == ST_NO_SPACE) && (out_result_block == '0))))
    else $error("bad status or block number in result");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_result_block (out_result_block),
  .out_free_blocks  (out_free_blocks)
);

`default_nettype wire

[tb/sv/bitmap_block_allocator_tb.sv]
// Self-checking testbench for the bitmap block allocator: directed cases, then random phases.
`timescale 1ns / 100ps

module bitmap_block_allocator_tb
  import bba_pkg::*;
;

  localparam int MAP_BLOCKS     = 65536;
  localparam int MAP_WORD       = 32;
  localparam int IDLE_MAX       = 11;
  localparam int MAX_REPORTS    = 10;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_ITEMS    = 40;
  localparam int COUNT_STEPS    = 16;
  localparam logic [CNT_W-1:0] CFG_MAX = 17'h1FFFF;

  // Action codes the block leaves unused.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  // One result item as the block reports it.
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  block;
    logic              read_bit;
    logic [CNT_W-1:0]  free;
  } outcome_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [ACT_W-1:0]  in_action;
  logic [BLK_W-1:0]  in_block_number;
  logic              in_bit_value;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [BLK_W-1:0]  out_result_block;
  logic              out_read_value;
  logic [CNT_W-1:0]  out_free_blocks;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Shadow copy of the allocator state and its registers.
  bit               used_map [MAP_BLOCKS];
  logic [CNT_W-1:0] free_cnt;
  logic [CNT_W-1:0] cfg_total;
  logic [CNT_W-1:0] cfg_reserved;

  outcome_t         alloc_outcomes[$];
  logic [BLK_W-1:0] held_blocks[$];
  int               error_count;
  int               idle_cycles;
  int               idle_max;

  bitmap_block_allocator #(
    .NUM_BLOCKS    (MAP_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_block_number  (in_block_number),
    .in_bit_value     (in_bit_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_block (out_result_block),
    .out_read_value   (out_read_value),
    .out_free_blocks  (out_free_blocks),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one action to the shadow map and count and returns the result it gives.
  function automatic outcome_t apply_action(logic [ACT_W-1:0] act, logic [BLK_W-1:0] blk,
                                            logic bv);
    outcome_t o;
    int       lim;
    int       res;
    int       hit;
    lim = (int'(cfg_total) < MAP_BLOCKS) ? int'(cfg_total) : MAP_BLOCKS;
    o.status   = ST_OK;
    o.block    = blk;
    o.read_bit = 1'b0;
    hit        = -1;
    case (act)
      ACT_FORMAT: begin
        res = (int'(cfg_reserved) < lim) ? int'(cfg_reserved) : lim;
        for (int n = 0; n < MAP_BLOCKS; n++) used_map[n] = (n < res);
        free_cnt = CNT_W'(lim - res);
        o.block  = '0;
      end
      ACT_ALLOC: begin
        // First fit: the lowest clear bit below the total, only while the count is nonzero.
        o.block = '0;
        if (free_cnt != '0) begin
          for (int n = 0; n < lim; n++) begin
            if (!used_map[n]) begin
              hit = n;
              break;
            end
          end
        end
        if (hit >= 0) begin
          used_map[hit] = 1'b1;
          free_cnt      = free_cnt - 1'b1;
          o.block       = BLK_W'(hit);
        end else begin
          o.status = ST_NO_SPACE;
        end
      end
      ACT_RELEASE, ACT_READ, ACT_WRITE: begin
        if (int'(blk) >= lim) begin
          o.status = ST_RANGE;
        end else if (act == ACT_RELEASE) begin
          // Only a used block is counted back, and the count saturates.
          if (used_map[blk]) begin
            used_map[blk] = 1'b0;
            if (free_cnt != COUNT_MAX) free_cnt = free_cnt + 1'b1;
          end
        end else if (act == ACT_READ) begin
          o.read_bit = used_map[blk];
        end else begin
          used_map[blk] = bv;
        end
      end
      default: begin
      end
    endcase
    o.free = free_cnt;
    return o;
  endfunction

  // Presents one item after a random gap and records its result once the block takes it.
  task automatic send_item(logic [ACT_W-1:0] act, logic [BLK_W-1:0] blk, logic bv);
    int       gap;
    outcome_t o;
    gap = $urandom_range(idle_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_action       <= act;
    in_block_number <= blk;
    in_bit_value    <= bv;
    do @(posedge clk); while (busy !== 1'b0);
    o = apply_action(act, blk, bv);
    alloc_outcomes.push_back(o);
    if (act == ACT_FORMAT) held_blocks.delete();
    if (act == ACT_ALLOC && o.status == ST_OK) held_blocks.push_back(o.block);
  endtask

  // Drops start and waits until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (alloc_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready. Upper data bits are noise.
  task automatic write_reg(logic idx, logic [CNT_W-1:0] value);
    logic [APB_DW-1:0] data;
    data              = $urandom();
    data[CNT_W-1:0]   = value;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_TOTAL) cfg_total = value;
    else cfg_reserved = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(logic [CNT_W-1:0] total, logic [CNT_W-1:0] reserved);
    wait_drained();
    write_reg(REG_TOTAL, total);
    write_reg(REG_RESERVED, reserved);
  endtask

  // Block number for a random item: mostly the low region where allocations land.
  function automatic logic [BLK_W-1:0] pick_block();
    int lim;
    int r;
    lim = (int'(cfg_total) < MAP_BLOCKS) ? int'(cfg_total) : MAP_BLOCKS;
    r   = $urandom_range(99, 0);
    if (r < 10 || lim == 0) return BLK_W'($urandom());
    if (r < 20) begin
      case ($urandom_range(4, 0))
        0:       return BLK_W'(lim - 1);
        1:       return BLK_W'(lim);
        2:       return BLK_W'(lim + 1);
        3:       return '0;
        default: return '1;
      endcase
    end
    if (r < 70) return BLK_W'($urandom_range(((lim < 128) ? lim : 128) - 1, 0));
    return BLK_W'($urandom_range(lim - 1, 0));
  endfunction

  // Before any format: the map is clear and the count is zero.
  task automatic test_unformatted_map();
    send_item(ACT_ALLOC, 16'h0000, 1'b0);
    send_item(ACT_READ, 16'hFFFF, 1'b0);
    send_item(ACT_RELEASE, 16'd5, 1'b1);
    send_item(ACT_WRITE, 16'd0, 1'b1);
    send_item(ACT_SPARE_LO, 16'hABCD, 1'b1);
    send_item(ACT_SPARE_HI, 16'h5432, 1'b0);
  endtask

  // A two-block map, filled by bit writes so the count is nonzero but no bit is free.
  task automatic test_small_map();
    set_config(17'd2, 17'd0);
    send_item(ACT_FORMAT, 16'h1234, 1'b1);
    send_item(ACT_WRITE, 16'd0, 1'b1);
    send_item(ACT_WRITE, 16'd1, 1'b1);
    send_item(ACT_ALLOC, 16'd0, 1'b0);
    send_item(ACT_RELEASE, 16'd1, 1'b0);
    send_item(ACT_ALLOC, 16'd0, 1'b0);
    send_item(ACT_READ, 16'd1, 1'b0);
    send_item(ACT_RELEASE, 16'hFFFF, 1'b0);
  endtask

  // Reserved prefix, double release and accesses at the total.
  task automatic test_reserved_prefix();
    set_config(17'd40, 17'd3);
    send_item(ACT_FORMAT, 16'd0, 1'b0);
    send_item(ACT_ALLOC, 16'd0, 1'b0);
    send_item(ACT_RELEASE, 16'd3, 1'b0);
    send_item(ACT_RELEASE, 16'd3, 1'b0);
    send_item(ACT_READ, 16'd40, 1'b0);
    send_item(ACT_WRITE, 16'd39, 1'b0);
  endtask

  // More reserved blocks than the total leaves nothing free.
  task automatic test_reserved_beyond_total();
    set_config(17'd5, 17'd9);
    send_item(ACT_FORMAT, 16'd0, 1'b0);
    send_item(ACT_ALLOC, 16'd0, 1'b0);
  endtask

  // A total of zero: every number is out of range.
  task automatic test_empty_map();
    set_config(17'd0, 17'd0);
    send_item(ACT_FORMAT, 16'd0, 1'b0);
    send_item(ACT_READ, 16'd0, 1'b0);
    send_item(ACT_ALLOC, 16'd0, 1'b0);
  endtask

  // Write then release blocks back to back so the free count climbs above the total.
  task automatic test_count_growth();
    set_config(CFG_MAX, 17'd0);
    idle_max = 0;
    send_item(ACT_FORMAT, 16'd0, 1'b0);
    for (int k = 0; k < COUNT_STEPS; k++) begin
      send_item(ACT_WRITE, BLK_W'(k), 1'b1);
      send_item(ACT_RELEASE, BLK_W'(k), 1'b0);
    end
    idle_max = IDLE_MAX;
  endtask

  // Random phases, each under its own register setting, mostly formatted first.
  task automatic test_random_phases();
    int               t;
    int               r;
    int               sel;
    int               pos;
    logic [ACT_W-1:0] act;
    logic [BLK_W-1:0] blk;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin t = MAP_BLOCKS; r = 0; end
        1: begin t = 64; r = 0; end
        2: begin t = 1; r = 0; end
        3: begin t = int'(CFG_MAX); r = int'(CFG_MAX); end
        4: begin t = 0; r = $urandom_range(int'(CFG_MAX), 0); end
        5: begin t = 100; r = 100; end
        6: begin t = $urandom_range(300, 1); r = $urandom_range(t + 10, 0); end
        7: begin t = MAP_BLOCKS; r = MAP_BLOCKS; end
        8: begin t = $urandom_range(2000, 1); r = $urandom_range(64, 0); end
        default: begin t = 33; r = 1; end
      endcase
      set_config(CNT_W'(t), CNT_W'(r));
      if ($urandom_range(4, 0) != 0) send_item(ACT_FORMAT, BLK_W'($urandom()), 1'($urandom()));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Stretches with and without gaps, and now and then a full drain.
        if (i % 15 == 0) idle_max = ($urandom_range(2, 0) == 0) ? 0 : IDLE_MAX;
        if ($urandom_range(39, 0) == 0) wait_drained();
        sel = $urandom_range(99, 0);
        blk = pick_block();
        if (sel < 4) act = ACT_FORMAT;
        else if (sel < 40) act = ACT_ALLOC;
        else if (sel < 65) act = ACT_RELEASE;
        else if (sel < 80) act = ACT_READ;
        else if (sel < 94) act = ACT_WRITE;
        else act = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        // Releases mostly return a block that an earlier allocate handed out.
        if (act == ACT_RELEASE && held_blocks.size() != 0 && $urandom_range(9, 0) < 7) begin
          pos = $urandom_range(held_blocks.size() - 1, 0);
          blk = held_blocks[pos];
          held_blocks.delete(pos);
        end
        send_item(act, blk, 1'($urandom()));
      end
    end
    idle_max = IDLE_MAX;
  endtask

  // Result checking and the watchdog on stalled traffic.
  always @(posedge clk) begin
    outcome_t want;
    if (out_valid === 1'b1) begin
      if (alloc_outcomes.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: status %0d block %0d read %0d free %0d",
                   out_status, out_result_block, out_read_value, out_free_blocks);
      end else begin
        want = alloc_outcomes.pop_front();
        if (out_status !== want.status || out_result_block !== want.block ||
            out_read_value !== want.read_bit || out_free_blocks !== want.free) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: expected status %0d block %0d read %0d free %0d, got %0d %0d %0d %0d",
                     want.status, want.block, want.read_bit, want.free,
                     out_status, out_result_block, out_read_value, out_free_blocks);
        end
      end
    end
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("bitmap_block_allocator_tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = ACT_FORMAT;
    in_block_number = '0;
    in_bit_value    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    error_count     = 0;
    idle_cycles     = 0;
    idle_max        = IDLE_MAX;
    free_cnt        = '0;
    cfg_total       = TOTAL_RESET;
    cfg_reserved    = '0;
    for (int n = 0; n < MAP_BLOCKS; n++) used_map[n] = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unformatted_map();
    test_small_map();
    test_reserved_prefix();
    test_reserved_beyond_total();
    test_empty_map();
    test_count_growth();
    test_random_phases();

    wait_drained();
    repeat (16) @(posedge clk);
    if (error_count == 0 && alloc_outcomes.size() == 0) begin
      $display("bitmap_block_allocator_tb passed");
    end else begin
      $display("bitmap_block_allocator_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bba_pkg.sv
rtl/bba_cfg.sv
rtl/bba_ctrl.sv
rtl/bba_dp.sv
rtl/bitmap_block_allocator.sv
rtl/bba_checker.sv
tb/sv/bitmap_block_allocator_tb.sv
